### hdl/motor_speed_ramp_pwm_split_defines.svh
// Assertion macros shared by the motor speed ramp RTL.
`ifndef MOTOR_SPEED_RAMP_PWM_SPLIT_DEFINES_SVH
`define MOTOR_SPEED_RAMP_PWM_SPLIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSRP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msrp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MSRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msrp: next-cycle check failed");

`endif

### hdl/msrp_pkg.sv
// Shared types and constants for the motor speed ramp block.
`timescale 1ns / 1ps

package msrp_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 23;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // command full scale and reciprocal of 25 (ceil(2^26 / 25)); the rounded-up
   // reciprocal gives the exact quotient for every dividend below 2^21
   localparam logic [7:0]  CMD_FULL    = 8'd200;
   localparam logic [21:0] RECIP_25    = 22'd2684355;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_BAND = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 4'd3;

   // reported motors: command byte that drives each, and inversion
   localparam int REPORTED = 4;
   localparam logic [1:0] SRC_BYTE [REPORTED] = '{2'd0, 2'd3, 2'd2, 2'd1};
   localparam logic       INVERTED [REPORTED] = '{1'b1, 1'b1, 1'b1, 1'b0};

   // one request to the shared multiplier
   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

### hdl/msrp_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module msrp_mul
   import msrp_pkg::*;
(
   input  logic                      clock,
   input  mul_req_type               req,
   output logic signed [MUL_P_W-1:0] prod_ff
);

   logic signed [MUL_P_W-1:0] prod_in;

   // one product per cycle, ready the cycle after the request
   assign prod_in = req.a * req.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hdl/motor_speed_ramp_pwm_split.sv
// Four-motor speed ramp with split forward/reverse PWM compare values.
// Each motor passes through SCALE, RECIP, TGT, MULP, MULD, UPD, FIN and DUTY on the
// shared multiplier; after the last motor, OUT loads the result once the output is free.
// A new item is accepted only in IDLE, not while one is in flight; the sequencer walks the
// motors one after another through the single multiplier.
// Reset (synchronous, active high) zeroes all motor state and loads config defaults.
`timescale 1ns / 1ps

module motor_speed_ramp_pwm_split
   import msrp_pkg::*;
#(
   parameter int MOTOR_COUNT = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   // command_first [7:0], command_second [15:8], command_third [23:16],
   // command_fourth [31:24]
   input  logic [31:0]          req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // fwd_duty_one, rev_duty_one, fwd_duty_two, rev_duty_two, fwd_duty_three,
   // rev_duty_three, fwd_duty_four, rev_duty_four, 16 bits each from bit 0 up
   output logic [127:0]         rsp_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata
);

`include "motor_speed_ramp_pwm_split_defines.svh"

   localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [MIDX_W-1:0] LAST_MOTOR = MIDX_W'(MOTOR_COUNT - 1);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCALE = 4'd1;
   localparam logic [3:0] ST_RECIP = 4'd2;
   localparam logic [3:0] ST_TGT   = 4'd3;
   localparam logic [3:0] ST_MULP  = 4'd4;
   localparam logic [3:0] ST_MULD  = 4'd5;
   localparam logic [3:0] ST_UPD   = 4'd6;
   localparam logic [3:0] ST_FIN   = 4'd7;
   localparam logic [3:0] ST_DUTY  = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [MIDX_W-1:0] motor_ff, motor_in;

   // configuration
   logic [15:0] max_speed_ff;
   logic [23:0] snap_band_ff;
   logic [15:0] gain_p_ff;
   logic [15:0] gain_d_ff;

   // per-motor state
   logic signed [25:0] set_speed_ff   [MOTOR_COUNT];
   logic signed [25:0] last_speed_ff  [MOTOR_COUNT];
   logic signed [25:0] change_ff      [MOTOR_COUNT];

   // item and working registers
   logic [7:0]         cmd_ff [REPORTED];
   logic [23:0]        tgt_ff;
   logic signed [26:0] err_ff;
   logic               outside_ff;
   logic signed [44:0] accp_ff;
   logic signed [25:0] snew_ff;
   logic [15:0]        fwd_ff [REPORTED];
   logic [15:0]        rev_ff [REPORTED];
   logic               rsp_valid_ff;
   logic [127:0]       rsp_data_ff;

   mul_req_type               mul_req;
   logic signed [MUL_P_W-1:0] prod;

   msrp_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .prod_ff (prod)
   );

   // current motor lookups
   logic [1:0]         rep_idx;
   logic               reported;
   logic [7:0]         cmd_raw;
   logic [7:0]         cmd_clamped;
   logic signed [25:0] speed_cur;
   logic [23:0]        max_q;

   assign rep_idx     = 2'(motor_ff);
   assign reported    = 32'(motor_ff) < REPORTED;
   assign cmd_raw     = cmd_ff[SRC_BYTE[rep_idx]];
   assign cmd_clamped = (cmd_raw > CMD_FULL) ? CMD_FULL : cmd_raw;
   assign speed_cur   = set_speed_ff[motor_ff];
   assign max_q       = {max_speed_ff, 8'd0};

   // multiplier operand select
   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_SCALE: begin
            mul_req.a = $signed({20'd0, cmd_clamped});
            mul_req.b = $signed({7'd0, max_speed_ff});
         end
         ST_RECIP: begin
            mul_req.a = $signed({7'd0, prod[23:3]});
            mul_req.b = $signed({1'b0, RECIP_25});
         end
         ST_MULP: begin
            mul_req.a = $signed({err_ff[26], err_ff});
            mul_req.b = $signed({7'd0, gain_p_ff});
         end
         ST_MULD: begin
            mul_req.a = $signed({{2{change_ff[motor_ff][25]}}, change_ff[motor_ff]});
            mul_req.b = $signed({7'd0, gain_d_ff});
         end
         default: mul_req = '0;
      endcase
   end

   // target: exact quotient by 25 from the reciprocal product, then inversion
   logic [15:0]        q_est;
   logic [15:0]        tgt_counts;
   logic [23:0]        tgt_in;
   logic signed [26:0] err_in;

   assign q_est      = prod[41:26];
   assign tgt_counts = INVERTED[rep_idx] ? (max_speed_ff - q_est) : q_est;
   assign tgt_in     = reported ? {tgt_counts, 8'd0} : 24'd0;
   assign err_in     = $signed({3'd0, tgt_in}) - $signed({speed_cur[25], speed_cur});

   // band test
   logic signed [26:0] band_s;
   logic               outside_in;

   assign band_s     = $signed({3'd0, snap_band_ff});
   assign outside_in = (err_ff > band_s) || (err_ff < -band_s);

   // ramp step: rounded sum, then saturate to 26 bits
   logic signed [44:0] acc;
   logic signed [29:0] ramp_sum;
   logic signed [25:0] ramp_sat;
   logic signed [25:0] snew_in;

   assign acc      = accp_ff + $signed(prod[44:0]);
   assign ramp_sum = $signed({{4{speed_cur[25]}}, speed_cur})
                   + $signed({acc[44], acc[44:16]});
   always_comb begin
      if (ramp_sum[29:25] == 5'b00000 || ramp_sum[29:25] == 5'b11111) begin
         ramp_sat = ramp_sum[25:0];
      end else if (ramp_sum[29]) begin
         ramp_sat = {1'b1, 25'd0};
      end else begin
         ramp_sat = {1'b0, {25{1'b1}}};
      end
   end
   assign snew_in = outside_ff ? ramp_sat : $signed({2'd0, tgt_ff});

   // change, history and upper clamp
   logic signed [26:0] diff;
   logic signed [25:0] change_in;
   logic signed [26:0] max_q_s;
   logic signed [25:0] set_in;

   assign diff = $signed({snew_ff[25], snew_ff})
               - $signed({last_speed_ff[motor_ff][25], last_speed_ff[motor_ff]});
   always_comb begin
      if (diff[26] == diff[25]) begin
         change_in = diff[25:0];
      end else if (diff[26]) begin
         change_in = {1'b1, 25'd0};
      end else begin
         change_in = {1'b0, {25{1'b1}}};
      end
   end
   assign max_q_s = $signed({3'd0, max_q});
   assign set_in  = ($signed({snew_ff[25], snew_ff}) > max_q_s) ? $signed({2'd0, max_q})
                                                                : snew_ff;

   // split duties around the midpoint
   logic signed [26:0] twice;
   logic signed [26:0] up_diff;
   logic signed [27:0] dn_diff;
   logic [19:0]        rev_wide;
   logic [15:0]        fwd_in;
   logic [15:0]        rev_in;

   assign twice    = {speed_cur, 1'b0};
   assign up_diff  = twice - max_q_s;
   assign dn_diff  = $signed({4'd0, max_q}) - $signed({twice[26], twice});
   assign rev_wide = dn_diff[27:8];
   always_comb begin
      fwd_in = 16'd0;
      rev_in = 16'd0;
      if (twice > max_q_s) begin
         fwd_in = up_diff[23:8];
      end else if (twice < max_q_s) begin
         rev_in = (rev_wide > {4'd0, max_speed_ff}) ? max_speed_ff : rev_wide[15:0];
      end
   end

   // sequencer
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      motor_in = motor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            motor_in = '0;
            if (req_tvalid) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_RECIP;
         ST_RECIP: state_in = ST_TGT;
         ST_TGT:   state_in = ST_MULP;
         ST_MULP:  state_in = ST_MULD;
         ST_MULD:  state_in = ST_UPD;
         ST_UPD:   state_in = ST_FIN;
         ST_FIN:   state_in = ST_DUTY;
         ST_DUTY: begin
            if (motor_ff == LAST_MOTOR) begin
               state_in = ST_OUT;
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_OUT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         motor_ff <= '0;
      end else begin
         state_ff <= state_in;
         motor_ff <= motor_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 16'd1000;
         snap_band_ff <= 24'd2560;
         gain_p_ff    <= 16'd6554;
         gain_d_ff    <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_SPEED: max_speed_ff <= csr_wdata[15:0];
            CSR_SNAP_BAND: snap_band_ff <= csr_wdata;
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata[15:0];
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // motor state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            set_speed_ff[i]  <= '0;
            last_speed_ff[i] <= '0;
            change_ff[i]     <= '0;
         end
      end else if (state_ff == ST_FIN) begin
         set_speed_ff[motor_ff]  <= set_in;
         last_speed_ff[motor_ff] <= snew_ff;
         change_ff[motor_ff]     <= change_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < REPORTED; i++) begin
            cmd_ff[i] <= req_tdata[8*i +: 8];
            fwd_ff[i] <= 16'd0;
            rev_ff[i] <= 16'd0;
         end
      end
      if (state_ff == ST_TGT) begin
         tgt_ff <= tgt_in;
         err_ff <= err_in;
      end
      if (state_ff == ST_MULP) outside_ff <= outside_in;
      if (state_ff == ST_MULD) accp_ff <= $signed(prod[44:0]) + 45'sd32768;
      if (state_ff == ST_UPD)  snew_ff <= snew_in;
      if (state_ff == ST_DUTY && reported) begin
         fwd_ff[rep_idx] <= fwd_in;
         rev_ff[rep_idx] <= rev_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         for (int i = 0; i < REPORTED; i++) begin
            rsp_data_ff[32*i +: 16]      <= fwd_ff[i];
            rsp_data_ff[32*i + 16 +: 16] <= rev_ff[i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `MSRP_ASSERT_NEXT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready), !req_tready)
   `MSRP_ASSERT_NEXT(a_out_load, clock, reset, (state_ff == ST_OUT && out_free), rsp_valid_ff)
   `MSRP_ASSERT_IMPLIES(a_speed_clamped, clock, reset, (state_ff == ST_DUTY),
                        (speed_cur <= $signed({2'd0, max_q})))
   `MSRP_ASSERT_IMPLIES(a_motor_range, clock, reset, (state_ff != ST_IDLE),
                        (32'(motor_ff) < MOTOR_COUNT))

endmodule
